// ===== rtl/rcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants of the record chunk sorter.
// Holds the input and result beat structs, the record type and key helpers.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned MaxRecordsDef  = 64;
  localparam int unsigned StringBytesDef = 16;
  localparam int unsigned IdW            = 31;

  typedef struct packed {
    logic [63:0]    surname_hi;
    logic [63:0]    surname_lo;
    logic [63:0]    given_hi;
    logic [63:0]    given_lo;
    logic [63:0]    city_hi;
    logic [63:0]    city_lo;
    logic [IdW-1:0] record_id;
    logic           last_in;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]    out_surname_hi;
    logic [63:0]    out_surname_lo;
    logic [63:0]    out_given_hi;
    logic [63:0]    out_given_lo;
    logic [63:0]    out_city_hi;
    logic [63:0]    out_city_lo;
    logic [IdW-1:0] out_id;
    logic           last_out;
    logic           overflow;
  } out_beat_t;

  // Record in key order: surname, given name, city, id (most significant first).
  typedef logic [6*64+IdW-1:0] rec_t;

  // Zeroes every byte after the first NUL and every byte at or past the limit.
  function automatic logic [127:0] canon_str(input logic [127:0] s,
                                             input int unsigned nbytes);
    logic [127:0] r;
    logic         ended;
    logic [7:0]   b;
    r     = '0;
    ended = 1'b0;
    for (int k = 0; k < 16; k++) begin
      b = s[127-8*k -: 8];
      if (ended || (k >= nbytes)) begin
        b = 8'h00;
      end else if (b == 8'h00) begin
        ended = 1'b1;
      end
      r[127-8*k -: 8] = b;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcs_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_cmp: registered key compare.
// Flags whether the new record orders strictly before the stored record; the
// 415-bit compare is split into seven word compares, merged in the next cycle.
// ----------------------------------------------------------------------------
module rcs_cmp (
  input  wire logic          clk_i,
  input  wire rcs_pkg::rec_t a_i,
  input  wire rcs_pkg::rec_t b_i,
  output logic               less_o
);

  localparam int unsigned RecW = $bits(rcs_pkg::rec_t);

  logic [6:0] lt_q, eq_q;
  logic [6:0] lt_d, eq_d;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lt_d[i] = a_i[RecW-1-64*i -: 64] < b_i[RecW-1-64*i -: 64];
      eq_d[i] = a_i[RecW-1-64*i -: 64] == b_i[RecW-1-64*i -: 64];
    end
    lt_d[6] = a_i[rcs_pkg::IdW-1:0] < b_i[rcs_pkg::IdW-1:0];
    eq_d[6] = a_i[rcs_pkg::IdW-1:0] == b_i[rcs_pkg::IdW-1:0];
  end

  always_ff @(posedge clk_i) begin
    lt_q <= lt_d;
    eq_q <= eq_d;
  end

  always_comb begin
    less_o = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (!eq_q[i]) less_o = lt_q[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/record_chunk_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// record_chunk_sorter: sorts the records of one chunk by surname, given name,
// city and id, and emits them in ascending order when the last record arrives.
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  in      | in_valid_i  | in_stall_o  | in_data_i  (rcs_pkg::in_beat_t)
//  out     | out_valid_o | out_stall_i | out_data_o (rcs_pkg::out_beat_t)
//
// A record is inserted by walking the store from the top: each stored entry is
// read (StRead), compared (StWait, StCmp) and moved up one place while the new
// record sorts strictly before it; the new record goes where the walk stops.
// in_stall_o holds off the next record until the insert is done. The memory
// has one read and one write port. Emptying a chunk reads (StDump) and issues
// (StOut) each record, holding while stalled. No clearing pass after reset.
// ----------------------------------------------------------------------------
module record_chunk_sorter #(
  parameter int unsigned MAX_RECORDS  = rcs_pkg::MaxRecordsDef,
  parameter int unsigned STRING_BYTES = rcs_pkg::StringBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rcs_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rcs_pkg::out_beat_t      out_data_o
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned IdW = rcs_pkg::IdW;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRead = 6'b000010,
    StWait = 6'b000100,
    StCmp  = 6'b001000,
    StDump = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  rcs_pkg::rec_t mem_q [MAX_RECORDS];
  rcs_pkg::rec_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  rcs_pkg::rec_t wr_data;

  rcs_pkg::rec_t new_q, new_d;
  logic          last_q, last_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;
  logic          less;
  logic          ovalid_q, ovalid_d;
  rcs_pkg::out_beat_t odata_q, odata_d;
  logic          rd_pend_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  rcs_cmp u_cmp (
    .clk_i  (clk_i),
    .a_i    (new_q),
    .b_i    (rd_q),
    .less_o (less)
  );

  logic [127:0] cs, cg, cc;
  always_comb begin
    cs = rcs_pkg::canon_str({in_data_i.surname_hi, in_data_i.surname_lo}, STRING_BYTES);
    cg = rcs_pkg::canon_str({in_data_i.given_hi, in_data_i.given_lo}, STRING_BYTES);
    cc = rcs_pkg::canon_str({in_data_i.city_hi, in_data_i.city_lo}, STRING_BYTES);
  end

  assign in_stall_o = (state_q != StIdle);
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ovalid_q && !out_stall_i;

  always_comb begin
    state_d  = state_q;
    new_d    = new_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = new_q;
    if (out_acc) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          new_d  = {cs, cg, cc, in_data_i.record_id};
          last_d = in_data_i.last_in;
          pos_d  = cnt_q;
          if (cnt_q == CW'(MAX_RECORDS)) begin
            ovf_d   = 1'b1;
            state_d = in_data_i.last_in ? StDump : StIdle;
            pos_d   = '0;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(0);
          cnt_d   = cnt_q + CW'(1);
          pos_d   = '0;
          state_d = last_q ? StDump : StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q - CW'(1));
          state_d = StWait;
        end
      end
      StWait: state_d = StCmp;
      StCmp: begin
        wr_en = 1'b1;
        wr_addr = AW'(pos_q);
        if (less) begin
          wr_data = rd_q;
          pos_d   = pos_q - CW'(1);
          state_d = StRead;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          pos_d   = '0;
          state_d = last_q ? StDump : StIdle;
        end
      end
      StDump: begin
        if (pos_q == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(pos_q);
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovalid_q || out_acc) begin
          ovalid_d = 1'b1;
          odata_d  = {rd_q[6*64+IdW-1 -: 6*64], rd_q[IdW-1:0],
                      (pos_q + CW'(1) == cnt_q), ovf_q};
          pos_d    = pos_q + CW'(1);
          state_d  = StDump;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      ovalid_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      ovalid_q  <= ovalid_d;
      rd_pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    odata_q <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RECORDS)) else $error("record count past store depth");
  a_wait_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait) |-> rd_pend_q) else $error("compare without a read");
  a_in_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == StIdle)) else $error("record taken while busy");
  a_out_from_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == StOut)) else $error("stray result beat");
`endif

endmodule
`default_nettype wire
